@@ sv/rti_pkg.sv @@
// Shared widths, types and helpers for the ray/triangle intersection unit.
`timescale 1ns / 1ps

package rti_pkg;

   localparam int COORD_BITS = 21;
   localparam int FRAC_BITS  = 10;
   localparam int VEC_W      = 63;
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * EDGE_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int NRM_W      = CROSS_W - FRAC_BITS;
   localparam int DPROD_W    = NRM_W + EDGE_W;
   localparam int DOT_W      = DPROD_W + 2;
   localparam int SUM_W      = DOT_W + 1;
   localparam int T_W        = 32;
   localparam int EPS_W      = 16;
   localparam int LIM_W      = T_W + 1;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
   localparam int Q_FRAC     = 16;
   localparam int INT_STEPS  = 15;
   localparam int DIV_STEPS  = INT_STEPS + Q_FRAC;
   localparam int DIV_LAT    = DIV_STEPS + 1;
   localparam int FRONT_LAT  = 6;
   localparam int MID_DEPTH  = 4;
   localparam int MID_PTR_W  = 2;
   localparam int OUT_DEPTH  = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]     edge_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [NRM_W-1:0]      nrm_type;
   typedef logic signed [DPROD_W-1:0]    dprod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic signed [LIM_W-1:0]      lim_type;
   typedef logic [EPS_W-1:0]             eps_type;

   typedef struct packed {
      logic [VEC_W-1:0] vertex_a;
      logic [VEC_W-1:0] vertex_b;
      logic [VEC_W-1:0] vertex_c;
      logic [VEC_W-1:0] ray_origin;
      logic [VEC_W-1:0] ray_direction;
      logic signed [T_W-1:0] closest_t;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic signed [T_W-1:0] hit_t;
      logic signed [T_W-1:0] bary_u;
      logic signed [T_W-1:0] bary_v;
   } rsp_type;

   // what the geometry front hands to the divide back end
   typedef struct packed {
      dot_type det;
      dot_type tnum;
      dot_type unum;
      dot_type vnum;
      lim_type lim;
      logic    pre_ok;
   } mid_type;

   function automatic coord_type coord_at(logic [VEC_W-1:0] v, int lane);
      return v[lane*COORD_BITS +: COORD_BITS];
   endfunction

endpackage

@@ sv/rti_front.sv @@
// Geometry front end: edges, normal, cross products, dot products, classification.
`timescale 1ns / 1ps

module rti_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rti_pkg::req_type  in_item,
   input  rti_pkg::eps_type  eps,
   input  logic              out_full,
   output logic              ready,
   output logic              out_valid,
   output rti_pkg::mid_type  out_item
);

   logic en;
   logic [rti_pkg::FRONT_LAT-1:0] valid_ff, valid_in;

   rti_pkg::edge_type  e0_1_in [3], e1_1_in [3], e2_1_in [3];
   rti_pkg::coord_type d_1_in [3];
   rti_pkg::lim_type   lim_1_in;
   rti_pkg::edge_type  e0_1_ff [3], e1_1_ff [3], e2_1_ff [3];
   rti_pkg::coord_type d_1_ff [3];
   rti_pkg::lim_type   lim_1_ff;

   rti_pkg::prod_type  nh_2_in [3], nl_2_in [3], mh_2_in [3], ml_2_in [3];
   rti_pkg::prod_type  nh_2_ff [3], nl_2_ff [3], mh_2_ff [3], ml_2_ff [3];
   rti_pkg::edge_type  e0_2_ff [3], e1_2_ff [3], e2_2_ff [3];
   rti_pkg::coord_type d_2_ff [3];
   rti_pkg::lim_type   lim_2_ff;

   rti_pkg::nrm_type   n_3_in [3], m_3_in [3];
   rti_pkg::nrm_type   n_3_ff [3], m_3_ff [3];
   rti_pkg::edge_type  e0_3_ff [3], e1_3_ff [3], e2_3_ff [3];
   rti_pkg::coord_type d_3_ff [3];
   rti_pkg::lim_type   lim_3_ff;

   rti_pkg::dprod_type qd_4_in [3], qt_4_in [3], qu_4_in [3], qv_4_in [3];
   rti_pkg::dprod_type qd_4_ff [3], qt_4_ff [3], qu_4_ff [3], qv_4_ff [3];
   rti_pkg::lim_type   lim_4_ff;

   rti_pkg::dot_type   det_5_in, tn_5_in, un_5_in, vn_5_in;
   rti_pkg::dot_type   det_5_ff, tn_5_ff, un_5_ff, vn_5_ff;
   rti_pkg::lim_type   lim_5_ff;

   rti_pkg::mid_type   mid_in, mid_ff;
   logic signed [rti_pkg::SUM_W-1:0] uv_sum;

   // whole front holds when its last item cannot enter the queue
   assign en        = !(valid_ff[rti_pkg::FRONT_LAT-1] && out_full);
   assign ready     = en;
   assign out_valid = valid_ff[rti_pkg::FRONT_LAT-1];
   assign out_item  = mid_ff;
   assign valid_in  = {valid_ff[rti_pkg::FRONT_LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: unpack and edges
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_1_in[i] = rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.vertex_b, i))
                    - rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.vertex_a, i));
         e1_1_in[i] = rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.vertex_a, i))
                    - rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.vertex_c, i));
         e2_1_in[i] = rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.vertex_a, i))
                    - rti_pkg::EDGE_W'(rti_pkg::coord_at(in_item.ray_origin, i));
         d_1_in[i]  = rti_pkg::coord_at(in_item.ray_direction, i);
      end
      lim_1_in = rti_pkg::LIM_W'(in_item.closest_t)
               - rti_pkg::LIM_W'($signed({1'b0, eps}));
   end

   // stage 2: cross product terms for n = e0 x e1 and m = e2 x d
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nh_2_in[i] = rti_pkg::PROD_W'(e0_1_ff[(i+1)%3]) * rti_pkg::PROD_W'(e1_1_ff[(i+2)%3]);
         nl_2_in[i] = rti_pkg::PROD_W'(e0_1_ff[(i+2)%3]) * rti_pkg::PROD_W'(e1_1_ff[(i+1)%3]);
         mh_2_in[i] = rti_pkg::PROD_W'(e2_1_ff[(i+1)%3]) * rti_pkg::PROD_W'(d_1_ff[(i+2)%3]);
         ml_2_in[i] = rti_pkg::PROD_W'(e2_1_ff[(i+2)%3]) * rti_pkg::PROD_W'(d_1_ff[(i+1)%3]);
      end
   end

   // stage 3: difference, floor to the coordinate fraction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_3_in[i] = rti_pkg::NRM_W'((rti_pkg::CROSS_W'(nh_2_ff[i])
                   - rti_pkg::CROSS_W'(nl_2_ff[i])) >>> rti_pkg::FRAC_BITS);
         m_3_in[i] = rti_pkg::NRM_W'((rti_pkg::CROSS_W'(mh_2_ff[i])
                   - rti_pkg::CROSS_W'(ml_2_ff[i])) >>> rti_pkg::FRAC_BITS);
      end
   end

   // stage 4: dot product terms
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qd_4_in[i] = rti_pkg::DPROD_W'(n_3_ff[i]) * rti_pkg::DPROD_W'(d_3_ff[i]);
         qt_4_in[i] = rti_pkg::DPROD_W'(n_3_ff[i]) * rti_pkg::DPROD_W'(e2_3_ff[i]);
         qu_4_in[i] = rti_pkg::DPROD_W'(m_3_ff[i]) * rti_pkg::DPROD_W'(e1_3_ff[i]);
         qv_4_in[i] = rti_pkg::DPROD_W'(m_3_ff[i]) * rti_pkg::DPROD_W'(e0_3_ff[i]);
      end
   end

   // stage 5: sums
   always_comb begin
      det_5_in = rti_pkg::DOT_W'(qd_4_ff[0]) + rti_pkg::DOT_W'(qd_4_ff[1])
               + rti_pkg::DOT_W'(qd_4_ff[2]);
      tn_5_in  = rti_pkg::DOT_W'(qt_4_ff[0]) + rti_pkg::DOT_W'(qt_4_ff[1])
               + rti_pkg::DOT_W'(qt_4_ff[2]);
      un_5_in  = rti_pkg::DOT_W'(qu_4_ff[0]) + rti_pkg::DOT_W'(qu_4_ff[1])
               + rti_pkg::DOT_W'(qu_4_ff[2]);
      vn_5_in  = rti_pkg::DOT_W'(qv_4_ff[0]) + rti_pkg::DOT_W'(qv_4_ff[1])
               + rti_pkg::DOT_W'(qv_4_ff[2]);
   end

   // stage 6: parallel-plane and barycentric range classification
   always_comb begin
      uv_sum      = rti_pkg::SUM_W'(un_5_ff) + rti_pkg::SUM_W'(vn_5_ff);
      mid_in.det  = det_5_ff;
      mid_in.tnum = tn_5_ff;
      mid_in.unum = un_5_ff;
      mid_in.vnum = vn_5_ff;
      mid_in.lim  = lim_5_ff;
      if (det_5_ff > 0) begin
         mid_in.pre_ok = (un_5_ff >= 0) && (vn_5_ff >= 0)
                       && (uv_sum <= rti_pkg::SUM_W'(det_5_ff));
      end else if (det_5_ff < 0) begin
         mid_in.pre_ok = (un_5_ff <= 0) && (vn_5_ff <= 0)
                       && (uv_sum >= rti_pkg::SUM_W'(det_5_ff));
      end else begin
         mid_in.pre_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_1_ff <= e0_1_in;
         e1_1_ff <= e1_1_in;
         e2_1_ff <= e2_1_in;
         d_1_ff  <= d_1_in;
         lim_1_ff <= lim_1_in;

         nh_2_ff <= nh_2_in;
         nl_2_ff <= nl_2_in;
         mh_2_ff <= mh_2_in;
         ml_2_ff <= ml_2_in;
         e0_2_ff <= e0_1_ff;
         e1_2_ff <= e1_1_ff;
         e2_2_ff <= e2_1_ff;
         d_2_ff  <= d_1_ff;
         lim_2_ff <= lim_1_ff;

         n_3_ff  <= n_3_in;
         m_3_ff  <= m_3_in;
         e0_3_ff <= e0_2_ff;
         e1_3_ff <= e1_2_ff;
         e2_3_ff <= e2_2_ff;
         d_3_ff  <= d_2_ff;
         lim_3_ff <= lim_2_ff;

         qd_4_ff <= qd_4_in;
         qt_4_ff <= qt_4_in;
         qu_4_ff <= qu_4_in;
         qv_4_ff <= qv_4_in;
         lim_4_ff <= lim_3_ff;

         det_5_ff <= det_5_in;
         tn_5_ff  <= tn_5_in;
         un_5_ff  <= un_5_in;
         vn_5_ff  <= vn_5_in;
         lim_5_ff <= lim_4_ff;

         mid_ff <= mid_in;
      end
   end

endmodule

@@ sv/rti_mid_queue.sv @@
// Short queue between the geometry front and the divide back end.
`timescale 1ns / 1ps

module rti_mid_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rti_pkg::mid_type push_item,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output rti_pkg::mid_type head_item
);

   rti_pkg::mid_type mem_ff [rti_pkg::MID_DEPTH];
   logic [rti_pkg::MID_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rti_pkg::MID_PTR_W:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == (rti_pkg::MID_PTR_W+1)'(rti_pkg::MID_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop  ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rti_pkg::MID_PTR_W+1)'(rti_pkg::MID_DEPTH))
      else $error("mid queue overfilled");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("back end popped an empty mid queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("front pushed into a full mid queue");

   a_pushpop_hold: assert property (@(posedge clock) disable iff (reset)
      (do_push && do_pop) |=> $stable(count_ff))
      else $error("count moved on simultaneous push and pop");

endmodule

@@ sv/rti_divider.sv @@
// Pipelined Q16.16 signed divider, one quotient bit per stage, saturating.
`timescale 1ns / 1ps

module rti_divider (
   input  logic                           clock,
   input  logic                           en,
   input  rti_pkg::dot_type               num,
   input  rti_pkg::dot_type               den,
   output logic signed [rti_pkg::T_W-1:0] quo
);

   localparam int MAG_W = rti_pkg::DOT_W;
   localparam int Q_W   = rti_pkg::DIV_STEPS;

   logic [MAG_W-1:0] nmag_in, nmag_ff, dmag_in, dmag_ff;
   logic             neg_in, neg_ff;

   logic [MAG_W:0]   rem_ff [rti_pkg::DIV_STEPS];
   logic [MAG_W-1:0] dd_ff  [rti_pkg::DIV_STEPS];
   logic [Q_W-1:0]   q_ff   [rti_pkg::DIV_STEPS];
   logic             ng_ff  [rti_pkg::DIV_STEPS];
   logic             ov_ff  [rti_pkg::DIV_STEPS];

   logic [rti_pkg::T_W-1:0] mag;

   // one restoring step; integer bits compare a shifted remainder,
   // fraction bits shift the remainder left
   function automatic logic [MAG_W+1:0] div_step(logic [MAG_W:0] rem,
                                                 logic [MAG_W-1:0] d, int s);
      logic [MAG_W:0] r;
      logic           b;
      int             j;
      r = rem;
      b = 1'b0;
      j = rti_pkg::INT_STEPS - 1 - s;
      if (s < rti_pkg::INT_STEPS) begin
         if ((r >> j) >= (MAG_W+1)'(d)) begin
            r = r - ((MAG_W+1)'(d) << j);
            b = 1'b1;
         end
      end else begin
         r = r << 1;
         if (r >= (MAG_W+1)'(d)) begin
            r = r - (MAG_W+1)'(d);
            b = 1'b1;
         end
      end
      return {b, r};
   endfunction

   always_comb begin
      neg_in  = num[MAG_W-1] ^ den[MAG_W-1];
      nmag_in = num[MAG_W-1] ? $unsigned(-num) : $unsigned(num);
      dmag_in = den[MAG_W-1] ? $unsigned(-den) : $unsigned(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         neg_ff  <= neg_in;
      end
   end

   for (genvar s = 0; s < rti_pkg::DIV_STEPS; s++) begin : g_step
      logic [MAG_W:0]   rem_prev;
      logic [MAG_W-1:0] d_prev;
      logic [Q_W-1:0]   q_prev;
      logic             ng_prev, ov_in;
      logic [MAG_W+1:0] res_in;
      if (s == 0) begin : g_first
         assign rem_prev = {1'b0, nmag_ff};
         assign d_prev   = dmag_ff;
         assign q_prev   = '0;
         assign ng_prev  = neg_ff;
         // quotient beyond the Q16.16 range
         assign ov_in    = (nmag_ff >> rti_pkg::INT_STEPS) >= dmag_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign d_prev   = dd_ff[s-1];
         assign q_prev   = q_ff[s-1];
         assign ng_prev  = ng_ff[s-1];
         assign ov_in    = ov_ff[s-1];
      end
      assign res_in = div_step(rem_prev, d_prev, s);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= res_in[MAG_W:0];
            dd_ff[s]  <= d_prev;
            q_ff[s]   <= {q_prev[Q_W-2:0], res_in[MAG_W+1]};
            ng_ff[s]  <= ng_prev;
            ov_ff[s]  <= ov_in;
         end
      end
   end

   always_comb begin
      mag = ov_ff[rti_pkg::DIV_STEPS-1] ? {1'b1, {(rti_pkg::T_W-1){1'b0}}}
                                        : {1'b0, q_ff[rti_pkg::DIV_STEPS-1]};
      if (ng_ff[rti_pkg::DIV_STEPS-1]) begin
         quo = -$signed(mag);
      end else if (mag[rti_pkg::T_W-1]) begin
         quo = {1'b0, {(rti_pkg::T_W-1){1'b1}}};
      end else begin
         quo = $signed(mag);
      end
   end

endmodule

@@ sv/rti_back.sv @@
// Divide back end: distance and barycentric quotients, window test, result.
`timescale 1ns / 1ps

module rti_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rti_pkg::mid_type in_item,
   input  rti_pkg::eps_type eps,
   input  logic             out_full,
   output logic             pop,
   output logic             out_valid,
   output rti_pkg::rsp_type out_item
);

   logic en;
   logic [rti_pkg::DIV_LAT-1:0] valid_ff, valid_in;
   logic [rti_pkg::DIV_LAT-1:0] ok_ff, ok_in;
   rti_pkg::lim_type            lim_ff [rti_pkg::DIV_LAT];
   logic                        last_ff, last_in;
   rti_pkg::rsp_type            rsp_ff, rsp_in;

   logic signed [rti_pkg::T_W-1:0] t_q, u_q, v_q;
   logic hit;

   assign en        = !(last_ff && out_full);
   assign pop       = en && in_valid;
   assign out_valid = last_ff;
   assign out_item  = rsp_ff;

   rti_divider u_div_t (.clock(clock), .en(en), .num(in_item.tnum), .den(in_item.det),
                        .quo(t_q));
   rti_divider u_div_u (.clock(clock), .en(en), .num(in_item.unum), .den(in_item.det),
                        .quo(u_q));
   rti_divider u_div_v (.clock(clock), .en(en), .num(in_item.vnum), .den(in_item.det),
                        .quo(v_q));

   assign valid_in = {valid_ff[rti_pkg::DIV_LAT-2:0], in_valid};
   assign ok_in    = {ok_ff[rti_pkg::DIV_LAT-2:0], in_item.pre_ok};
   assign last_in  = valid_ff[rti_pkg::DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_ff  <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff     <= ok_in;
         lim_ff[0] <= in_item.lim;
         for (int i = 1; i < rti_pkg::DIV_LAT; i++) begin
            lim_ff[i] <= lim_ff[i-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   // distance window on the saturated quotient
   always_comb begin
      hit = ok_ff[rti_pkg::DIV_LAT-1]
         && (rti_pkg::LIM_W'(t_q) >= rti_pkg::LIM_W'($signed({1'b0, eps})))
         && (rti_pkg::LIM_W'(t_q) <= lim_ff[rti_pkg::DIV_LAT-1]);
      rsp_in.hit    = hit;
      rsp_in.hit_t  = hit ? t_q : '0;
      rsp_in.bary_u = hit ? u_q : '0;
      rsp_in.bary_v = hit ? v_q : '0;
   end

endmodule

@@ sv/ray_triangle_intersect_unit.sv @@
// Top level of the ray/triangle intersection unit.
`timescale 1ns / 1ps

//  channel   ports                          direction   accepted when
//  request   req_push req_full req_item     in          req_push && !req_full
//  response  rsp_empty rsp_pop rsp_item     out         rsp_pop && !rsp_empty
//  csr       csr_we csr_wdata               in          csr_we (hit_epsilon)
//
// One item per cycle sustained while the receiver keeps popping; a result goes
// from the edge that takes its item through 6 geometry stages, the 4-entry
// mid queue, a divider input register and 31 quotient stages (one bit per
// stage, three dividers side by side), a result register and the 2-entry
// response queue.
// Reset is synchronous, active high; it empties all queues and pipelines and
// sets hit_epsilon to 66. A stalled response queue holds the back end, a
// full mid queue holds the front; each side stalls on its own.
module ray_triangle_intersect_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rti_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rti_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  rti_pkg::eps_type csr_wdata
);

   rti_pkg::eps_type eps_ff, eps_in;

   logic             front_ready, front_valid;
   rti_pkg::mid_type front_item;
   logic             mid_full, mid_empty, mid_pop;
   rti_pkg::mid_type mid_head;
   logic             back_valid;
   rti_pkg::rsp_type back_item;

   // response queue
   rti_pkg::rsp_type out_ff [rti_pkg::OUT_DEPTH];
   logic             out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [1:0]       out_cnt_ff, out_cnt_in;
   logic             out_full, out_push, out_pop;

   assign eps_in = csr_we ? csr_wdata : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= rti_pkg::EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   assign req_full = !front_ready;

   rti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_push),
      .in_item   (req_item),
      .eps       (eps_ff),
      .out_full  (mid_full),
      .ready     (front_ready),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   rti_mid_queue u_mid (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && !mid_full),
      .push_item (front_item),
      .pop       (mid_pop),
      .full      (mid_full),
      .empty     (mid_empty),
      .head_item (mid_head)
   );

   rti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_item   (mid_head),
      .eps       (eps_ff),
      .out_full  (out_full),
      .pop       (mid_pop),
      .out_valid (back_valid),
      .out_item  (back_item)
   );

   // two-entry response queue decouples the pop side from the back end
   assign out_full  = (out_cnt_ff == 2'(rti_pkg::OUT_DEPTH));
   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign out_push  = back_valid && !out_full;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_item  = out_ff[out_rd_ff];

   always_comb begin
      out_wr_in  = out_push ? !out_wr_ff : out_wr_ff;
      out_rd_in  = out_pop  ? !out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= back_item;
      end
   end

endmodule

@@ test/ray_triangle_intersect_unit_tb.sv @@
// Self-checking testbench for the ray/triangle intersection unit.
`timescale 1ns / 1ps

module ray_triangle_intersect_unit_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   rti_pkg::req_type req_item;
   logic             rsp_empty;
   logic             rsp_pop;
   rti_pkg::rsp_type rsp_item;
   logic             csr_we;
   rti_pkg::eps_type csr_wdata;

   ray_triangle_intersect_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct {
      longint x;
      longint y;
      longint z;
   } vec_type;

   rti_pkg::rsp_type expected_hits[$];
   rti_pkg::eps_type epsilon_model;
   int      error_count;
   int      idle_cycles;
   int      hold_pop;     // long receiver hold-off, counted down in its own process
   bit      pop_gaps_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint lane_of(logic [rti_pkg::VEC_W-1:0] v, int lane);
      logic signed [rti_pkg::COORD_BITS-1:0] c;
      c = v[lane*rti_pkg::COORD_BITS +: rti_pkg::COORD_BITS];
      return longint'(c);
   endfunction

   function automatic vec_type unpack_vec(logic [rti_pkg::VEC_W-1:0] v);
      vec_type r;
      r.x = lane_of(v, 0);
      r.y = lane_of(v, 1);
      r.z = lane_of(v, 2);
      return r;
   endfunction

   function automatic vec_type vdiff(vec_type a, vec_type b);
      vec_type r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
   endfunction

   // arithmetic shift is floor rounding
   function automatic vec_type cross_floor(vec_type a, vec_type b);
      vec_type r;
      r.x = (a.y * b.z - a.z * b.y) >>> rti_pkg::FRAC_BITS;
      r.y = (a.z * b.x - a.x * b.z) >>> rti_pkg::FRAC_BITS;
      r.z = (a.x * b.y - a.y * b.x) >>> rti_pkg::FRAC_BITS;
      return r;
   endfunction

   function automatic longint dotp(vec_type a, vec_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   // num/den as Q16.16, truncated toward zero, saturated
   function automatic longint q16_quotient(longint num, longint den);
      longint unsigned n, d, whole, rem, mag;
      bit neg;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      whole = n / d;
      rem = n % d;
      if (whole >= 64'd32768) mag = 64'h8000_0000;
      else begin
         mag = whole;
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            mag = mag << 1;
            if (rem >= d) begin
               rem -= d;
               mag |= 1;
            end
         end
      end
      if (neg) return -longint'(mag);
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return longint'(mag);
   endfunction

   function automatic rti_pkg::rsp_type predict_hit(rti_pkg::req_type r);
      rti_pkg::rsp_type res;
      vec_type a, b, c, o, d, e0, e1, e2, n, im;
      longint det, t, un, vn, eps, closest;
      bit ok;
      res = '0;
      a = unpack_vec(r.vertex_a);
      b = unpack_vec(r.vertex_b);
      c = unpack_vec(r.vertex_c);
      o = unpack_vec(r.ray_origin);
      d = unpack_vec(r.ray_direction);
      closest = longint'(r.closest_t);
      eps = longint'(epsilon_model);
      e0 = vdiff(b, a);
      e1 = vdiff(a, c);
      e2 = vdiff(a, o);
      n = cross_floor(e0, e1);
      det = dotp(n, d);
      if (det == 0) return res;
      t = q16_quotient(dotp(n, e2), det);
      if (t < eps || t > closest - eps) return res;
      im = cross_floor(e2, d);
      un = dotp(im, e1);
      vn = dotp(im, e0);
      if (det > 0) ok = un >= 0 && vn >= 0 && un + vn <= det;
      else ok = un <= 0 && vn <= 0 && un + vn >= det;
      if (!ok) return res;
      res.hit = 1'b1;
      res.hit_t = t[31:0];
      res.bary_u = 32'(q16_quotient(un, det));
      res.bary_v = 32'(q16_quotient(vn, det));
      return res;
   endfunction

   // ---------------- helpers ----------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int random_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [rti_pkg::VEC_W-1:0] pack_vec(longint x, longint y, longint z);
      logic [rti_pkg::VEC_W-1:0] v;
      v[20:0]  = x[20:0];
      v[41:21] = y[20:0];
      v[62:42] = z[20:0];
      return v;
   endfunction

   function automatic logic [rti_pkg::VEC_W-1:0] rand_vec();
      return rti_pkg::VEC_W'({$urandom(), $urandom()});
   endfunction

   // small coordinate, units of 1/1024
   function automatic longint small_coord(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // sends one item, with a random gap first unless the gap is suppressed;
   // push stays high after the accepting edge until the next item or a drain
   task automatic send_ray(rti_pkg::req_type r, bit gaps = 1);
      int g;
      g = gaps ? random_gap() : 0;
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_item <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_hits.push_back(predict_hit(r));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_epsilon(rti_pkg::eps_type v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      epsilon_model = v;
   endtask

   // ray through a triangle near the origin: origin on -z side, dir +z mostly
   function automatic rti_pkg::req_type facing_ray();
      rti_pkg::req_type r;
      r.vertex_a = pack_vec(small_coord(4096), small_coord(4096), small_coord(2048));
      r.vertex_b = pack_vec(small_coord(4096), small_coord(4096), small_coord(2048));
      r.vertex_c = pack_vec(small_coord(4096), small_coord(4096), small_coord(2048));
      r.ray_origin = pack_vec(small_coord(1024), small_coord(1024),
                              -longint'($urandom_range(1024, 16384)));
      r.ray_direction = pack_vec(small_coord(256), small_coord(256),
                                 longint'($urandom_range(1, 2048)));
      r.closest_t = $urandom_range(0, 7) == 0 ? $urandom() : 32'h7FFF_FFFF;
      return r;
   endfunction

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      rti_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_hits.size() == 0) begin
            report_mismatch("results with none expected", 1, 0);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_item.hit !== want.hit) report_mismatch("hit", rsp_item.hit, want.hit);
            if (rsp_item.hit_t !== want.hit_t)
               report_mismatch("hit_t", rsp_item.hit_t, want.hit_t);
            if (rsp_item.bary_u !== want.bary_u)
               report_mismatch("bary_u", rsp_item.bary_u, want.bary_u);
            if (rsp_item.bary_v !== want.bary_v)
               report_mismatch("bary_v", rsp_item.bary_v, want.bary_v);
         end
      end
   end

   // receiver: random pop gaps, or a long hold-off when asked
   initial begin
      int g;
      g = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pop > 0) begin
            hold_pop--;
            rsp_pop <= 1'b0;
         end else if (g > 0) begin
            g--;
            rsp_pop <= 1'b0;
         end else if (pop_gaps_on && $urandom_range(0, 3) == 0) begin
            g = random_gap();
            rsp_pop <= g == 0;
            if (g > 0) g--;
         end else
            rsp_pop <= 1'b1;
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      rti_pkg::req_type r;
      // unit right triangle in z=1, ray from origin along +z: clean hit
      r.vertex_a = pack_vec(0, 0, 1024);
      r.vertex_b = pack_vec(1024, 0, 1024);
      r.vertex_c = pack_vec(0, 1024, 1024);
      r.ray_origin = pack_vec(256, 256, 0);
      r.ray_direction = pack_vec(0, 0, 1024);
      r.closest_t = 32'h7FFF_FFFF;
      send_ray(r);
      // hit exactly on a vertex and on an edge
      r.ray_origin = pack_vec(0, 0, 0);
      send_ray(r);
      r.ray_origin = pack_vec(512, 512, 0);
      send_ray(r);
      // outside the triangle
      r.ray_origin = pack_vec(1024, 1024, 0);
      send_ray(r);
      // behind origin: t negative
      r.ray_origin = pack_vec(256, 256, 4096);
      send_ray(r);
      // closest distance too near
      r.ray_origin = pack_vec(256, 256, 0);
      r.closest_t = 32'h0000_8000;
      send_ray(r);
      r.closest_t = 32'h8000_0000;
      send_ray(r);
      // reverse direction: positive determinant
      r.closest_t = 32'h7FFF_FFFF;
      r.ray_origin = pack_vec(256, 256, 2048);
      r.ray_direction = pack_vec(0, 0, -1024);
      send_ray(r);
      // parallel ray: zero determinant
      r.ray_direction = pack_vec(1024, 0, 0);
      send_ray(r);
      // degenerate triangle
      r.vertex_b = r.vertex_a;
      send_ray(r);
      // tiny direction: saturated distance
      r.vertex_b = pack_vec(1024, 0, 1024);
      r.ray_origin = pack_vec(256, 256, -1000000);
      r.ray_direction = pack_vec(0, 0, 1);
      send_ray(r);
      // coordinate extremes and all-ones / all-zero fields
      r.vertex_a = pack_vec(-1048576, -1048576, -1048576);
      r.vertex_b = pack_vec(1048575, -1048576, 1048575);
      r.vertex_c = pack_vec(-1048576, 1048575, 1048575);
      r.ray_origin = pack_vec(1048575, 1048575, -1048576);
      r.ray_direction = pack_vec(-1048576, 1048575, 1048575);
      send_ray(r);
      r = '1;
      send_ray(r);
      r = '0;
      send_ray(r);
      for (int i = 0; i < 8; i++) send_ray(facing_ray());
   endtask

   task automatic test_random(int count);
      rti_pkg::req_type r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            r.vertex_a = rand_vec();
            r.vertex_b = rand_vec();
            r.vertex_c = rand_vec();
            r.ray_origin = rand_vec();
            r.ray_direction = rand_vec();
            r.closest_t = $urandom();
         end else
            r = facing_ray();
         send_ray(r);
      end
   endtask

   // receiver stalls long while the sender keeps pushing into a full block
   task automatic test_backpressure();
      hold_pop = 120;
      for (int i = 0; i < 60; i++) send_ray(facing_ray(), 0);
      // sender pauses until everything is back
      wait_drained();
   endtask

   task automatic test_epsilon_sweep();
      write_epsilon(16'd0);
      test_random(40);
      write_epsilon(16'hFFFF);
      test_random(40);
      write_epsilon(16'd1024);
      test_random(40);
   endtask

   initial begin
      error_count = 0;
      hold_pop = 0;
      pop_gaps_on = 1'b0;
      epsilon_model = rti_pkg::EPS_RESET;
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      pop_gaps_on = 1'b1;
      test_random(150);
      test_backpressure();
      test_epsilon_sweep();
      write_epsilon(rti_pkg::EPS_RESET);
      test_random(100);

      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
sv/rti_pkg.sv
sv/rti_front.sv
sv/rti_mid_queue.sv
sv/rti_divider.sv
sv/rti_back.sv
sv/ray_triangle_intersect_unit.sv
test/ray_triangle_intersect_unit_tb.sv
